// ===== hdl/sewd_pkg.sv =====
// Shared types and constants of the sound event window detector.
package sewd_pkg;

    localparam int ENERGY_W  = 32;
    localparam int FRAME_W   = 9;
    localparam int MODE_W    = 2;
    localparam int QUIET_W   = 8;
    localparam int WINDOW_W  = 20;
    localparam int GATHER_W  = 21;
    localparam int SUM_W     = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W = 6;

    localparam int MAX_FRAMES_DEF = 256;

    localparam logic [ENERGY_W-1:0] TRIGGER_RST = 32'd1000;
    localparam logic [ENERGY_W-1:0] QUIET_RST   = 32'd500;
    localparam logic [QUIET_W-1:0]  QWIN_RST    = 8'd3;
    localparam logic [WINDOW_W-1:0] WINDOW_RST  = 20'd16000;

    localparam logic [MODE_W-1:0] PH_IDLE      = 2'd0;
    localparam logic [MODE_W-1:0] PH_GATHER    = 2'd1;
    localparam logic [MODE_W-1:0] PH_STREAM    = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUIET   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_QWIN    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW  = 2'd3;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    typedef enum logic [4:0] {
        ST_READY = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    typedef enum logic {
        KIND_TRIGGER = 1'b0,
        KIND_WINDOW  = 1'b1
    } kind_t;

    typedef struct packed {
        logic                went_idle;
        logic [ENERGY_W-1:0] average_volume;
        logic                window_done;
        logic                triggered;
        logic [MODE_W-1:0]   mode;
    } result_t;

endpackage

// ===== hdl/sound_event_window_detector.sv =====
// Sound event window detector with a bit-serial divider for averages and trigger checks.
//
// Items enter on the s_ group and each produces exactly one result item on the m_ group.
// The loudest of the three channel energies is the block level. In idle, a block whose
// level per frame exceeds trigger_level starts an event. While active, levels and frame
// counts are summed until window_samples frames are gathered; then a window result
// carries the average volume, and enough quiet windows in a row return to idle.
// The user must write registers through cfg_wr_en, cfg_addr and cfg_wdata only while no
// item is open; the block itself does not enforce this. After acceptance an item is
// evaluated; when a division is needed it then passes through the restoring divider (one
// quotient bit per cycle), a finishing step and the output register. A window of zero
// frames skips the divider, and a muted block or one that needs no division goes from
// evaluation to the output register. Items are accepted only in the ready state.
// The output register holds a finished result while the receiver stalls, and the next
// item is accepted and worked on meanwhile; it waits in its last step until the output
// register frees up.
// Reset clears the phase, the sums and the quiet run, restores the register defaults
// and empties the output register.
module sound_event_window_detector
    import sewd_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // energy_left, energy_right, energy_back, frame_count, muted, zero fill
    input  logic [111:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mode, triggered, window_done, average_volume, went_idle, zero fill
    output logic [39:0]           m_tdata
);

    state_t                state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [ENERGY_W-1:0]   trigger_reg, trigger_next;
    logic [ENERGY_W-1:0]   quiet_lvl_reg, quiet_lvl_next;
    logic [QUIET_W-1:0]    qwin_reg, qwin_next;
    logic [WINDOW_W-1:0]   window_reg, window_next;
    logic [MODE_W-1:0]     phase_reg, phase_next;
    logic [GATHER_W-1:0]   gathered_reg, gathered_next;
    logic [QUIET_W-1:0]    quiet_run_reg, quiet_run_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [ENERGY_W-1:0]   level_reg, level_next;
    logic [FRAME_W-1:0]    frames_reg, frames_next;
    logic                  muted_reg, muted_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [GATHER_W-1:0]   rem_reg, rem_next;
    logic [GATHER_W-1:0]   divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    result_t               res_reg, res_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [ENERGY_W-1:0]   in_left, in_right, in_back, in_max;
    logic [FRAME_W-1:0]    in_frames, in_clamped;
    logic [SUM_W:0]        sum_wide;
    logic [SUM_W-1:0]      sum_sat;
    logic [GATHER_W:0]     gather_wide;
    logic [GATHER_W-1:0]   gather_sat;
    logic [GATHER_W:0]     trial;
    logic                  trial_ok;
    logic [ENERGY_W-1:0]   avg;
    logic [QUIET_W-1:0]    quiet_inc;

    assign in_left   = s_tdata[31:0];
    assign in_right  = s_tdata[63:32];
    assign in_back   = s_tdata[95:64];
    assign in_frames = s_tdata[104:96];

    assign s_tready = (state_reg == ST_READY);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

    always_comb
    begin
        in_max = in_left;
        if (in_right > in_max)
        begin
            in_max = in_right;
        end
        if (in_back > in_max)
        begin
            in_max = in_back;
        end
        in_clamped = in_frames;
        if (int'(in_frames) > MAX_FRAMES)
        begin
            in_clamped = FRAME_W'(MAX_FRAMES);
        end
    end

    always_comb
    begin
        sum_wide    = {1'b0, sum_reg} + {{(SUM_W - ENERGY_W + 1){1'b0}}, level_reg};
        sum_sat     = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        gather_wide = {1'b0, gathered_reg} + {{(GATHER_W - FRAME_W + 1){1'b0}}, frames_reg};
        gather_sat  = gather_wide[GATHER_W] ? {GATHER_W{1'b1}} : gather_wide[GATHER_W-1:0];
        trial       = {rem_reg, quo_reg[SUM_W-1]};
        trial_ok    = (trial >= {1'b0, divisor_reg});
        avg         = (|quo_reg[SUM_W-1:ENERGY_W]) ? {ENERGY_W{1'b1}} : quo_reg[ENERGY_W-1:0];
        quiet_inc   = (quiet_run_reg != {QUIET_W{1'b1}}) ? quiet_run_reg + 1'b1 : quiet_run_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        trigger_next   = trigger_reg;
        quiet_lvl_next = quiet_lvl_reg;
        qwin_next      = qwin_reg;
        window_next    = window_reg;
        phase_next     = phase_reg;
        gathered_next  = gathered_reg;
        quiet_run_next = quiet_run_reg;
        sum_next       = sum_reg;
        level_next     = level_reg;
        frames_next    = frames_reg;
        muted_next     = muted_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_TRIGGER: trigger_next   = cfg_wdata;
                REG_QUIET:   quiet_lvl_next = cfg_wdata;
                REG_QWIN:    qwin_next      = cfg_wdata[QUIET_W-1:0];
                REG_WINDOW:  window_next    = cfg_wdata[WINDOW_W-1:0];
                default:     window_next    = window_reg;
            endcase
        end

        unique case (state_reg)
            ST_READY:
            begin
                if (s_tvalid)
                begin
                    level_next  = in_max;
                    frames_next = in_clamped;
                    muted_next  = s_tdata[105];
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                res_next = '{went_idle: 1'b0, average_volume: '0, window_done: 1'b0,
                             triggered: 1'b0, mode: phase_reg};
                rem_next = '0;
                cnt_next = DIV_LAST;
                if (muted_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (phase_reg == PH_IDLE)
                begin
                    if (frames_reg == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        kind_next    = KIND_TRIGGER;
                        quo_next     = {{(SUM_W - ENERGY_W){1'b0}}, level_reg};
                        divisor_next = {{(GATHER_W - FRAME_W){1'b0}}, frames_reg};
                        state_next   = ST_DIV;
                    end
                end
                else
                begin
                    sum_next      = sum_sat;
                    gathered_next = gather_sat;
                    if (gather_sat >= {1'b0, window_reg})
                    begin
                        kind_next    = KIND_WINDOW;
                        quo_next     = sum_sat;
                        divisor_next = gather_sat;
                        if (gather_sat == '0)
                        begin
                            quo_next   = '0;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ok ? GATHER_W'(trial - {1'b0, divisor_reg})
                                    : trial[GATHER_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], trial_ok};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (kind_reg == KIND_TRIGGER)
                begin
                    if (quo_reg > {{(SUM_W - ENERGY_W){1'b0}}, trigger_reg})
                    begin
                        phase_next         = PH_GATHER;
                        gathered_next      = {{(GATHER_W - FRAME_W){1'b0}}, frames_reg};
                        sum_next           = {{(SUM_W - ENERGY_W){1'b0}}, level_reg};
                        res_next.triggered = 1'b1;
                        res_next.mode      = PH_GATHER;
                    end
                end
                else
                begin
                    res_next.window_done    = 1'b1;
                    res_next.average_volume = avg;
                    gathered_next           = '0;
                    sum_next                = '0;
                    phase_next              = (phase_reg == PH_GATHER) ? PH_STREAM : phase_reg;
                    if (avg < quiet_lvl_reg)
                    begin
                        quiet_run_next = quiet_inc;
                        if (quiet_inc >= qwin_reg)
                        begin
                            phase_next         = PH_IDLE;
                            quiet_run_next     = '0;
                            res_next.went_idle = 1'b1;
                        end
                    end
                    else
                    begin
                        quiet_run_next = '0;
                    end
                    res_next.mode = phase_next;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            kind_reg      <= KIND_TRIGGER;
            trigger_reg   <= TRIGGER_RST;
            quiet_lvl_reg <= QUIET_RST;
            qwin_reg      <= QWIN_RST;
            window_reg    <= WINDOW_RST;
            phase_reg     <= PH_IDLE;
            gathered_reg  <= '0;
            quiet_run_reg <= '0;
            sum_reg       <= '0;
            level_reg     <= '0;
            frames_reg    <= '0;
            muted_reg     <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            divisor_reg   <= '0;
            cnt_reg       <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            trigger_reg   <= trigger_next;
            quiet_lvl_reg <= quiet_lvl_next;
            qwin_reg      <= qwin_next;
            window_reg    <= window_next;
            phase_reg     <= phase_next;
            gathered_reg  <= gathered_next;
            quiet_run_reg <= quiet_run_next;
            sum_reg       <= sum_next;
            level_reg     <= level_next;
            frames_reg    <= frames_next;
            muted_reg     <= muted_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            divisor_reg   <= divisor_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_idle_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.went_idle |-> out_reg.mode == PH_IDLE)
        else $error("went_idle result without idle mode");

    a_trigger_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.triggered |->
            out_reg.mode == PH_GATHER && !out_reg.window_done)
        else $error("trigger result with wrong mode or window");

    a_avg_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.average_volume != '0 |-> out_reg.window_done)
        else $error("average volume outside a window result");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && cnt_reg == '0 |=> state_reg == ST_FIN)
        else $error("divider did not finish after its last step");

endmodule

// ===== verif/sound_event_window_detector_tb.sv =====
// Self-checking testbench of the sound event window detector: directed table, then random blocks.
module sound_event_window_detector_tb;
    import sewd_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int NUM_PHASES = 9;
    localparam int BLOCKS_PER_PHASE = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [ENERGY_W-1:0] ALL_ONES = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [GATHER_W-1:0] GATHER_MAX = '1;

    typedef struct packed {
        logic                muted;
        logic [FRAME_W-1:0]  frame_count;
        logic [ENERGY_W-1:0] energy_back;
        logic [ENERGY_W-1:0] energy_right;
        logic [ENERGY_W-1:0] energy_left;
    } audio_block_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] value;
        audio_block_t          blk;
        bit                    typed;
        result_t               expected;
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [111:0]          s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;

    logic [ENERGY_W-1:0] trigger_level_q;
    logic [ENERGY_W-1:0] quiet_level_q;
    logic [QUIET_W-1:0]  quiet_windows_q;
    logic [WINDOW_W-1:0] window_samples_q;

    logic [MODE_W-1:0]   det_phase;
    logic [GATHER_W-1:0] frames_acc;
    logic [QUIET_W-1:0]  quiet_count;
    logic [SUM_W-1:0]    level_sum;

    result_t   pending_results[$];
    step_row_t directed_rows[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int cycle_count;
    int fail_count;
    int blocks_sent;
    int results_seen;
    int windows_seen;
    int triggers_seen;
    int idles_seen;
    int settings_used;

    sound_event_window_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    function automatic result_t predict_block(input audio_block_t blk);
        result_t             res;
        logic [FRAME_W-1:0]  frames;
        logic [ENERGY_W-1:0] loudest;
        logic [SUM_W:0]      sum_next;
        logic [GATHER_W:0]   frames_next;
        logic [SUM_W-1:0]    quotient;
        res = '0;
        frames = (blk.frame_count > MAX_FRAMES_DEF) ? FRAME_W'(MAX_FRAMES_DEF) : blk.frame_count;
        loudest = blk.energy_left;
        if (blk.energy_right > loudest)
        begin
            loudest = blk.energy_right;
        end
        if (blk.energy_back > loudest)
        begin
            loudest = blk.energy_back;
        end
        if (!blk.muted)
        begin
            if (det_phase == PH_IDLE)
            begin
                if (frames != 0 && (loudest / frames) > trigger_level_q)
                begin
                    det_phase = PH_GATHER;
                    frames_acc = GATHER_W'(frames);
                    level_sum = SUM_W'(loudest);
                    res.triggered = 1'b1;
                end
            end
            else
            begin
                sum_next = {1'b0, level_sum} + (SUM_W + 1)'(loudest);
                level_sum = (sum_next > SUM_MAX) ? SUM_MAX : sum_next[SUM_W-1:0];
                frames_next = {1'b0, frames_acc} + (GATHER_W + 1)'(frames);
                frames_acc = (frames_next > GATHER_MAX) ? GATHER_MAX : frames_next[GATHER_W-1:0];
                if (frames_acc >= window_samples_q)
                begin
                    res.window_done = 1'b1;
                    if (frames_acc != 0)
                    begin
                        quotient = level_sum / frames_acc;
                        res.average_volume = (quotient > SUM_W'(ALL_ONES)) ? ALL_ONES
                                                                           : quotient[ENERGY_W-1:0];
                    end
                    if (det_phase == PH_GATHER)
                    begin
                        det_phase = PH_STREAM;
                    end
                    frames_acc = '0;
                    level_sum = '0;
                    if (res.average_volume < quiet_level_q)
                    begin
                        if (quiet_count != '1)
                        begin
                            quiet_count = quiet_count + 1'b1;
                        end
                        if (quiet_count >= quiet_windows_q)
                        begin
                            det_phase = PH_IDLE;
                            quiet_count = '0;
                            res.went_idle = 1'b1;
                        end
                    end
                    else
                    begin
                        quiet_count = '0;
                    end
                end
            end
        end
        res.mode = det_phase;
        return res;
    endfunction

    function automatic step_row_t blk_row(input logic [ENERGY_W-1:0] el, er, eb,
                                          input logic [FRAME_W-1:0] frames, input logic muted,
                                          input bit typed = 1'b0, input result_t res = '0);
        step_row_t row;
        row = '{default: '0};
        row.blk = '{muted: muted, frame_count: frames, energy_back: eb, energy_right: er,
                    energy_left: el};
        row.typed = typed;
        row.expected = res;
        return row;
    endfunction

    function automatic step_row_t reg_row(input logic [CFG_ADDR_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        step_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.value = value;
        return row;
    endfunction

    function automatic logic [ENERGY_W-1:0] rand_energy();
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: return $urandom_range(1) ? ALL_ONES : '0;
            default: return $urandom_range(200000);
        endcase
    endfunction

    function automatic audio_block_t rand_block();
        audio_block_t blk;
        int pick;
        blk.energy_left = rand_energy();
        blk.energy_right = rand_energy();
        blk.energy_back = rand_energy();
        pick = $urandom_range(99);
        if (pick < 5)
            blk.frame_count = FRAME_W'($urandom_range(511, MAX_FRAMES_DEF + 1));
        else if (pick < 10)
            blk.frame_count = '0;
        else if (pick < 15)
            blk.frame_count = FRAME_W'(MAX_FRAMES_DEF);
        else
            blk.frame_count = FRAME_W'($urandom_range(64, 1));
        blk.muted = ($urandom_range(9) == 0);
        return blk;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_TRIGGER: trigger_level_q = value;
            REG_QUIET:   quiet_level_q = value;
            REG_QWIN:    quiet_windows_q = value[QUIET_W-1:0];
            REG_WINDOW:  window_samples_q = value[WINDOW_W-1:0];
            default:     ;
        endcase
        settings_used++;
    endtask

    task automatic send_block(input audio_block_t blk, input bit typed = 1'b0,
                              input result_t typed_res = '0);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata = {6'b0, blk};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = predict_block(blk);
        pending_results.push_back(typed ? typed_res : predicted);
        blocks_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic randomize_config();
        logic [CFG_DATA_W-1:0] value;
        case ($urandom_range(9))
            0: value = '0;
            1: value = ALL_ONES;
            2: value = $urandom;
            default: value = $urandom_range(6000, 100);
        endcase
        write_reg(REG_TRIGGER, value);
        case ($urandom_range(9))
            0: value = '0;
            1: value = ALL_ONES;
            2: value = $urandom;
            default: value = $urandom_range(8000, 100);
        endcase
        write_reg(REG_QUIET, value);
        case ($urandom_range(9))
            0: value = 255;
            1: value = 1;
            default: value = $urandom_range(5, 1);
        endcase
        write_reg(REG_QWIN, value);
        case ($urandom_range(9))
            0: value = (1 << WINDOW_W) - 1;
            1: value = 1;
            default: value = $urandom_range(400, 2);
        endcase
        write_reg(REG_WINDOW, value);
    endtask

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[36:0]);
            results_seen++;
            windows_seen += got.window_done;
            triggers_seen += got.triggered;
            idles_seen += got.went_idle;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: got mode %0d trig %0b done %0b avg %0h idle %0b",
                         $time, got.mode, got.triggered, got.window_done, got.average_volume,
                         got.went_idle);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.mode !== want.mode || got.triggered !== want.triggered ||
                    got.window_done !== want.window_done ||
                    got.average_volume !== want.average_volume ||
                    got.went_idle !== want.went_idle)
                begin
                    $display("%0t: mismatch: expected mode %0d trig %0b done %0b avg %0h idle %0b",
                             $time, want.mode, want.triggered, want.window_done,
                             want.average_volume, want.went_idle);
                    $display("%0t:           got mode %0d trig %0b done %0b avg %0h idle %0b",
                             $time, got.mode, got.triggered, got.window_done,
                             got.average_volume, got.went_idle);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                     pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        cycle_count = 0;
        fail_count = 0;
        blocks_sent = 0;
        results_seen = 0;
        windows_seen = 0;
        triggers_seen = 0;
        idles_seen = 0;
        settings_used = 0;
        trigger_level_q = TRIGGER_RST;
        quiet_level_q = QUIET_RST;
        quiet_windows_q = QWIN_RST;
        window_samples_q = WINDOW_RST;
        det_phase = PH_IDLE;
        frames_acc = '0;
        quiet_count = '0;
        level_sum = '0;

        directed_rows.push_back(blk_row(ALL_ONES, ALL_ONES, ALL_ONES, 9'd256, 1'b1, 1'b1,
                                        result_t'{mode: PH_IDLE, default: '0}));
        directed_rows.push_back(blk_row(ALL_ONES, ALL_ONES, ALL_ONES, 9'd0, 1'b0, 1'b1,
                                        result_t'{mode: PH_IDLE, default: '0}));
        directed_rows.push_back(blk_row(0, 0, 4000, 9'd4, 1'b0, 1'b1,
                                        result_t'{mode: PH_IDLE, default: '0}));
        directed_rows.push_back(blk_row(1, 2, 4004, 9'd4, 1'b0, 1'b1,
                                        result_t'{mode: PH_GATHER, triggered: 1'b1,
                                                  default: '0}));
        directed_rows.push_back(blk_row(ALL_ONES, ALL_ONES, ALL_ONES, 9'd256, 1'b1, 1'b1,
                                        result_t'{mode: PH_GATHER, default: '0}));
        directed_rows.push_back(reg_row(REG_WINDOW, 1));
        directed_rows.push_back(blk_row(0, ALL_ONES, 0, 9'd0, 1'b0));
        directed_rows.push_back(blk_row(ALL_ONES, 0, 0, 9'd0, 1'b0));
        directed_rows.push_back(blk_row(0, 0, ALL_ONES, 9'd1, 1'b0));
        directed_rows.push_back(blk_row(0, 0, 0, 9'd1, 1'b0));
        directed_rows.push_back(blk_row(0, 0, 0, 9'd1, 1'b0));
        directed_rows.push_back(blk_row(0, 0, 0, 9'd1, 1'b0));
        directed_rows.push_back(reg_row(REG_TRIGGER, ALL_ONES));
        directed_rows.push_back(blk_row(ALL_ONES, ALL_ONES, ALL_ONES, 9'd1, 1'b0, 1'b1,
                                        result_t'{mode: PH_IDLE, default: '0}));
        directed_rows.push_back(reg_row(REG_TRIGGER, 0));
        directed_rows.push_back(blk_row(0, 0, 0, 9'd1, 1'b0, 1'b1,
                                        result_t'{mode: PH_IDLE, default: '0}));
        directed_rows.push_back(blk_row(0, 0, 1, 9'd1, 1'b0, 1'b1,
                                        result_t'{mode: PH_GATHER, triggered: 1'b1,
                                                  default: '0}));
        directed_rows.push_back(blk_row(5, 7, 3, 9'd511, 1'b0));
        directed_rows.push_back(reg_row(REG_QWIN, 1));
        directed_rows.push_back(reg_row(REG_QUIET, ALL_ONES));
        directed_rows.push_back(blk_row(10, 0, 0, 9'd2, 1'b0));
        directed_rows.push_back(reg_row(REG_QWIN, 255));
        directed_rows.push_back(reg_row(REG_QUIET, 0));
        directed_rows.push_back(reg_row(REG_WINDOW, (1 << WINDOW_W) - 1));
        directed_rows.push_back(blk_row(0, 0, 1, 9'd1, 1'b0));
        directed_rows.push_back(blk_row(1, 0, 0, 9'd256, 1'b0));

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                send_block(directed_rows[i].blk, directed_rows[i].typed,
                           directed_rows[i].expected);
            end
        end

        for (int phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++)
        begin
            wait_drained();
            randomize_config();
            case (phase_idx % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            if (phase_idx == 0)
            begin
                @(posedge clk);
                hold_left = HOLD_OFF_CYCLES;
                @(negedge clk);
            end
            for (int n = 0; n < BLOCKS_PER_PHASE; n++)
            begin
                if (phase_idx == 1 && n == BLOCKS_PER_PHASE / 2)
                    wait_drained();
                send_block(rand_block());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d blocks and checked %0d results over %0d register writes.",
                 blocks_sent, results_seen, settings_used);
        $display("Saw %0d event starts, %0d completed windows and %0d returns to idle.",
                 triggers_seen, windows_seen, idles_seen);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
